FILE: rtl/lps_pkg.sv
// Shared types and constants for the line position steering block.
`timescale 1ns / 1ps

package lps_pkg;

    localparam int SENSOR_W  = 8;
    localparam int SPEED_W   = 7;
    localparam int SUM_W     = 5;
    localparam int OFFSET_W  = 5;
    localparam int DRIVE_W   = 8;

    // Run end-index sum before any run has been seen.
    localparam logic signed [SUM_W-1:0] SUM_RESET  = -5'sd2;
    // Sum of a run centered between sensors 3 and 4.
    localparam logic signed [SUM_W-1:0] SUM_CENTER = 5'sd7;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    // floor(v * 5 / 12) == (v * RECIP_K) >> RECIP_SHIFT for 0 <= v <= 255.
    localparam int RECIP_K_W   = 11;
    localparam logic [RECIP_K_W-1:0] RECIP_K = 11'd1707;
    localparam int RECIP_SHIFT = 12;

    typedef struct packed {
        logic                    seen;
        logic signed [SUM_W-1:0] sum;
    } run_info_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
    } drive_pair_t;

endpackage

FILE: rtl/lps_run_find.sv
// Finds the first longest run of set sensor bits and its start+end index sum.
`timescale 1ns / 1ps

module lps_run_find (
    input  logic [lps_pkg::SENSOR_W-1:0] sensor_bits,
    output lps_pkg::run_info_t           run_info
);

    always_comb begin
        logic [3:0]                      cur_len;
        logic [3:0]                      best_len;
        logic [2:0]                      cur_start;
        logic signed [lps_pkg::SUM_W-1:0] best_sum;
        cur_len   = 4'd0;
        best_len  = 4'd0;
        cur_start = 3'd0;
        best_sum  = lps_pkg::SUM_RESET;
        for (int i = 0; i < lps_pkg::SENSOR_W; i++) begin
            if (sensor_bits[i]) begin
                if (cur_len == 4'd0) begin
                    cur_start = 3'(i);
                end
                cur_len = cur_len + 4'd1;
                // strict compare keeps the lowest-index run on ties
                if (cur_len > best_len) begin
                    best_len = cur_len;
                    best_sum = signed'({2'b00, cur_start} + 5'(i));
                end
            end else begin
                cur_len = 4'd0;
            end
        end
        run_info.seen = |sensor_bits;
        run_info.sum  = best_sum;
    end

endmodule

FILE: rtl/lps_steer.sv
// Left and right steering values from wheel speed and the held line offset.
`timescale 1ns / 1ps

module lps_steer (
    input  logic [lps_pkg::SPEED_W-1:0]         wheel_speed,
    input  logic signed [lps_pkg::OFFSET_W-1:0] held_offset,
    output lps_pkg::drive_pair_t                drive
);

    localparam int ACC_W  = 10;
    localparam int MAG_W  = 9;
    localparam int PROD_W = MAG_W + lps_pkg::RECIP_K_W;

    // trunc(x * 5 / 12), rounding toward zero
    function automatic logic signed [lps_pkg::DRIVE_W-1:0] scale(
        input logic signed [ACC_W-1:0] x
    );
        logic [MAG_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [lps_pkg::DRIVE_W-1:0] q;
        mag  = x[ACC_W-1] ? MAG_W'(-x) : MAG_W'(x);
        prod = PROD_W'(mag) * PROD_W'(lps_pkg::RECIP_K);
        q    = prod[lps_pkg::RECIP_SHIFT +: lps_pkg::DRIVE_W];
        return x[ACC_W-1] ? signed'(-q) : signed'(q);
    endfunction

    logic signed [ACC_W-1:0] speed2;
    logic signed [ACC_W-1:0] off_ext;
    logic signed [ACC_W-1:0] off5;

    assign speed2  = signed'({2'b00, wheel_speed, 1'b0});
    assign off_ext = ACC_W'(held_offset);
    assign off5    = (off_ext <<< 2) + off_ext;

    assign drive.left  = scale(speed2 - off5);
    assign drive.right = scale(speed2 + off5);

endmodule

FILE: rtl/line_position_steering_top.sv
// Top level of the line position steering block.
`timescale 1ns / 1ps
// Usage:
//   The s_ channel carries one 8-bit line sensor sample per transaction
//   (s_valid / s_ready). The m_ channel returns exactly one result per
//   sample: left_drive, right_drive, line_offset_half and line_seen
//   (m_valid / m_ready). The wheel speed register is written through
//   cfg_wr_en / cfg_wr_data; values above 100 are clamped to 100. Write it
//   only while no sample is in flight.
// Timing:
//   A sample is captured in an input register; run finding and steering math
//   sit between that register and the result register, which drives
//   m_valid. Throughput is one sample per cycle while m_ready stays high,
//   set by the single input register / result register pair.
// Stalls:
//   While m_ready is low the result register holds its transaction; the
//   input register still takes one more sample, then s_ready drops until
//   the result drains.
// Reset:
//   aresetn low (synchronous) empties both registers, sets wheel speed to
//   0, the run sum to "no run yet" (offset -10 half steps), and the held
//   offset and drive values to 0.

module line_position_steering_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lps_pkg::SPEED_W-1:0]         cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lps_pkg::SENSOR_W-1:0]        s_sensor_bits,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lps_pkg::DRIVE_W-1:0]  m_left_drive,
    output logic signed [lps_pkg::DRIVE_W-1:0]  m_right_drive,
    output logic signed [lps_pkg::OFFSET_W-1:0] m_line_offset_half,
    output logic                                m_line_seen
);

    // Configuration and per-item state
    logic [lps_pkg::SPEED_W-1:0]         speed_reg;
    logic signed [lps_pkg::SUM_W-1:0]    sum_reg;
    logic signed [lps_pkg::OFFSET_W-1:0] offset_reg;
    lps_pkg::drive_pair_t                held_reg;

    // Input register
    logic                                in_vld_reg;
    logic [lps_pkg::SENSOR_W-1:0]        in_bits_reg;

    // Result register
    logic                                out_vld_reg;
    lps_pkg::drive_pair_t                out_drive_reg;
    logic signed [lps_pkg::OFFSET_W-1:0] out_offset_reg;
    logic                                out_seen_reg;

    logic                                s_take;
    logic                                advance;
    lps_pkg::run_info_t                  run_info;
    lps_pkg::drive_pair_t                calc_drive;
    lps_pkg::drive_pair_t                drive_next;
    logic signed [lps_pkg::SUM_W-1:0]    sum_next;
    logic signed [lps_pkg::OFFSET_W-1:0] offset_next;

    // Move the input item into the result register when the result slot
    // is free or is being drained this cycle.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_take  = s_valid && s_ready;

    lps_run_find u_run_find (
        .sensor_bits (in_bits_reg),
        .run_info    (run_info)
    );

    // Steering uses the offset stored by the previous item.
    lps_steer u_steer (
        .wheel_speed (speed_reg),
        .held_offset (offset_reg),
        .drive       (calc_drive)
    );

    always_comb begin
        sum_next   = run_info.seen ? run_info.sum : sum_reg;
        drive_next = run_info.seen ? calc_drive : held_reg;
        if (sum_next > lps_pkg::SUM_CENTER) begin
            offset_next = sum_next - 5'sd6;
        end else if (sum_next < lps_pkg::SUM_CENTER) begin
            offset_next = sum_next - 5'sd8;
        end else begin
            offset_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg   <= '0;
            sum_reg     <= lps_pkg::SUM_RESET;
            offset_reg  <= '0;
            held_reg    <= '0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            // clamp the speed on write
            if (cfg_wr_en) begin
                speed_reg <= (cfg_wr_data > lps_pkg::SPEED_MAX) ?
                             lps_pkg::SPEED_MAX : cfg_wr_data;
            end
            if (s_take) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                sum_reg     <= sum_next;
                offset_reg  <= offset_next;
                held_reg    <= drive_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_bits_reg <= s_sensor_bits;
        end
        if (advance) begin
            out_drive_reg  <= drive_next;
            out_offset_reg <= offset_next;
            out_seen_reg   <= run_info.seen;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_left_drive       = out_drive_reg.left;
    assign m_right_drive      = out_drive_reg.right;
    assign m_line_offset_half = out_offset_reg;
    assign m_line_seen        = out_seen_reg;

endmodule

FILE: rtl/lps_checker.sv
// Port-level checks for the line position steering block, with bind.
`timescale 1ns / 1ps

module lps_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [lps_pkg::DRIVE_W-1:0]  m_left_drive,
    input logic signed [lps_pkg::DRIVE_W-1:0]  m_right_drive,
    input logic signed [lps_pkg::OFFSET_W-1:0] m_line_offset_half,
    input logic                                m_line_seen
);

    // Hold a stalled result transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_drive) &&
        $stable(m_right_drive) && $stable(m_line_offset_half) &&
        $stable(m_line_seen))
        else $error("stalled result changed");

    // Drop s_ready only when a result is stuck at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input blocked without output stall");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Offset is in -10..8 and never -1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line_offset_half >= -5'sd10) &&
        (m_line_offset_half <= 5'sd8) && (m_line_offset_half != -5'sd1))
        else $error("line offset out of range");

endmodule

bind line_position_steering_top lps_checker u_lps_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_left_drive       (m_left_drive),
    .m_right_drive      (m_right_drive),
    .m_line_offset_half (m_line_offset_half),
    .m_line_seen        (m_line_seen)
);
